>>> src/xcpd_pkg.sv
`timescale 1ns / 1ps
package xcpd_pkg;

    // Deframer phase, one-hot
    typedef enum logic [4:0] {
        t_PH_HUNT = 5'b00001,
        t_PH_CMD  = 5'b00010,
        t_PH_LEN  = 5'b00100,
        t_PH_DATA = 5'b01000,
        t_PH_CKS  = 5'b10000
    } t_phase;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // Register map: word index within the APB window
    localparam logic REG_START_MARKER = 1'b0;

    localparam logic [7:0] START_MARKER_RST = 8'hFF;

    typedef struct packed {
        logic        stored_valid;
        logic [7:0]  stored_byte;
        logic [7:0]  stored_index;
        logic [2:0]  slot_index;
        logic        frame_end;
        logic        frame_ok;
        logic [15:0] good_count;
        logic [15:0] bad_count;
    } t_result;

endpackage

>>> src/xcpd_if.sv
`timescale 1ns / 1ps
interface xcpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcpd_out_if;
    logic        valid;
    logic        ready;
    logic        stored_valid;
    logic [7:0]  stored_byte;
    logic [7:0]  stored_index;
    logic [2:0]  slot_index;
    logic        frame_end;
    logic        frame_ok;
    logic [15:0] good_count;
    logic [15:0] bad_count;

    modport source (
        output valid, output stored_valid, output stored_byte, output stored_index,
        output slot_index, output frame_end, output frame_ok, output good_count,
        output bad_count, input ready
    );
    modport sink (
        input valid, input stored_valid, input stored_byte, input stored_index,
        input slot_index, input frame_end, input frame_ok, input good_count,
        input bad_count, output ready
    );
endinterface

>>> src/xor_checked_packet_deframer_core.sv
`timescale 1ns / 1ps
// Start-byte / length / XOR-checksum deframer. Each request on i_rx carries
// one received byte and yields exactly one result request on o_res, in order.
// Throughput is one byte per clock while o_res is not stalled: the byte is
// captured in an input register, the frame state (phase, fill count, length,
// running XOR, ring slot, good and bad counters) updates from that register,
// and the result lands in an output register. A byte in the input register
// advances only when the output register is empty or being drained, so a
// stalled sink holds it back. While the sink stalls, at most two
// bytes are held (one in each register); the input stays ready while a
// finished result waits as long as the input register is free or draining.
// The start marker (reset 0xFF) is an APB register at byte address 0 and must
// only be written while idle.
module xor_checked_packet_deframer_core #(
    parameter int RING_SLOTS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    xcpd_in_if.sink                      i_rx,
    xcpd_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [xcpd_pkg::PADDR_W-1:0] paddr,
    input  logic [xcpd_pkg::PDATA_W-1:0] pwdata,
    output logic [xcpd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    xcpd_pkg::t_result r_out;
    xcpd_pkg::t_result w_res;
    logic [7:0]        w_start_marker;
    logic              w_advance;

    xcpd_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_start_marker (w_start_marker)
    );

    // Advance the held byte when the result register is empty or being drained
    assign w_advance = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_advance;

    // Input register: capture a new request, drop the entry once it advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Frame state update and result formation, one byte per step
    xcpd_fsm #(
        .RING_SLOTS (RING_SLOTS)
    ) u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_advance),
        .i_byte         (r_in_byte),
        .i_start_marker (w_start_marker),
        .o_res          (w_res)
    );

    // Result register: hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.stored_valid = r_out.stored_valid;
    assign o_res.stored_byte  = r_out.stored_byte;
    assign o_res.stored_index = r_out.stored_index;
    assign o_res.slot_index   = r_out.slot_index;
    assign o_res.frame_end    = r_out.frame_end;
    assign o_res.frame_ok     = r_out.frame_ok;
    assign o_res.good_count   = r_out.good_count;
    assign o_res.bad_count    = r_out.bad_count;

endmodule

>>> src/xcpd_cfg.sv
`timescale 1ns / 1ps
module xcpd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xcpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [xcpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [xcpd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [7:0]                    o_start_marker
);

    logic [7:0] r_marker;
    logic       w_sel_marker;

    assign pready       = 1'b1;
    assign w_sel_marker = (paddr[2] == xcpd_pkg::REG_START_MARKER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= xcpd_pkg::START_MARKER_RST;
        end else if (psel && penable && pwrite && pready && w_sel_marker) begin
            r_marker <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_marker) begin
            prdata = {{(xcpd_pkg::PDATA_W-8){1'b0}}, r_marker};
        end
    end

    assign o_start_marker = r_marker;

endmodule

>>> src/xcpd_fsm.sv
`timescale 1ns / 1ps
module xcpd_fsm #(
    parameter int RING_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_start_marker,
    output xcpd_pkg::t_result o_res
);

    localparam int SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(RING_SLOTS - 1);

    xcpd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_fill, n_fill;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_xor, n_xor;
    logic [SW-1:0]    r_slot, n_slot;
    logic [15:0]      r_good, n_good;
    logic [15:0]      r_bad, n_bad;
    logic [SW+2:0]    w_slot_ext;
    logic [7:0]       w_fill_inc;

    assign w_slot_ext = {3'b000, r_slot};
    assign w_fill_inc = r_fill + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_len   = r_len;
        n_xor   = r_xor;
        n_slot  = r_slot;
        n_good  = r_good;
        n_bad   = r_bad;
        o_res   = '0;
        o_res.slot_index = w_slot_ext[2:0];

        unique case (r_phase)
            xcpd_pkg::t_PH_CMD: begin
                o_res.stored_valid = 1'b1;
                o_res.stored_byte  = i_byte;
                o_res.stored_index = r_fill;
                n_fill  = w_fill_inc;
                n_xor   = i_byte;
                n_phase = xcpd_pkg::t_PH_LEN;
            end
            xcpd_pkg::t_PH_LEN: begin
                o_res.stored_valid = 1'b1;
                o_res.stored_byte  = i_byte;
                o_res.stored_index = r_fill;
                n_fill  = w_fill_inc;
                n_len   = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_phase = (i_byte != 8'd0) ? xcpd_pkg::t_PH_DATA : xcpd_pkg::t_PH_CKS;
            end
            xcpd_pkg::t_PH_DATA: begin
                o_res.stored_valid = 1'b1;
                o_res.stored_byte  = i_byte;
                o_res.stored_index = r_fill;
                n_fill = w_fill_inc;
                n_xor  = r_xor ^ i_byte;
                if (w_fill_inc >= r_len) begin
                    n_phase = xcpd_pkg::t_PH_CKS;
                end
            end
            xcpd_pkg::t_PH_CKS: begin
                o_res.frame_end = 1'b1;
                if (i_byte == r_xor) begin
                    o_res.frame_ok = 1'b1;
                    n_slot = (r_slot >= SLOT_LAST) ? '0 : r_slot + SW'(1);
                    n_good = r_good + 16'd1;
                end else begin
                    n_bad = r_bad + 16'd1;
                end
                n_fill  = 8'd0;
                n_phase = xcpd_pkg::t_PH_HUNT;
            end
            default: begin
                n_phase = (i_byte == i_start_marker) ? xcpd_pkg::t_PH_CMD
                                                     : xcpd_pkg::t_PH_HUNT;
            end
        endcase

        o_res.good_count = n_good;
        o_res.bad_count  = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xcpd_pkg::t_PH_HUNT;
            r_fill  <= '0;
            r_len   <= '0;
            r_xor   <= '0;
            r_slot  <= '0;
            r_good  <= '0;
            r_bad   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_xor   <= n_xor;
            r_slot  <= n_slot;
            r_good  <= n_good;
            r_bad   <= n_bad;
        end
    end

endmodule

>>> src/xcpd_checker.sv
`timescale 1ns / 1ps
module xcpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_stored_valid,
    input logic [7:0]  i_stored_byte,
    input logic [7:0]  i_stored_index,
    input logic        i_frame_end,
    input logic        i_frame_ok,
    input logic [15:0] i_good_count,
    input logic [15:0] i_bad_count
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_good_count) && $stable(i_bad_count)
            && $stable(i_stored_byte) && $stable(i_frame_end))
        else $error("result changed while stalled");

    a_ok_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_ok |-> i_frame_end)
        else $error("frame_ok without frame_end");

    a_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_stored_valid |-> !i_frame_end)
        else $error("stored byte flagged as checksum");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_stored_valid |-> i_stored_byte == 8'd0 && i_stored_index == 8'd0)
        else $error("unstored result carries data");

endmodule

bind xor_checked_packet_deframer_core xcpd_checker u_xcpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_stored_valid (o_res.stored_valid),
    .i_stored_byte  (o_res.stored_byte),
    .i_stored_index (o_res.stored_index),
    .i_frame_end    (o_res.frame_end),
    .i_frame_ok     (o_res.frame_ok),
    .i_good_count   (o_res.good_count),
    .i_bad_count    (o_res.bad_count)
);
